/* src/timer_table_scheduler_unit_defines.svh */
// ---------------------------------------------------------------------------
// Timer table scheduler assertion macros
// Shared property forms for the scheduler's checks.
// ---------------------------------------------------------------------------
`ifndef TIMER_TABLE_SCHEDULER_UNIT_DEFINES_SVH
`define TIMER_TABLE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tts_pkg.sv */
// ---------------------------------------------------------------------------
// Timer table scheduler package
// Sizes, operation codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package tts_pkg;

    localparam int SLOTS         = 16;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int TIME_BITS     = 48;
    localparam int INTERVAL_BITS = 32;
    localparam int EXP_W         = TIME_BITS + 1;
    localparam int WAIT_W        = 33;
    localparam int IN_DATA_W     = 88;
    localparam int OUT_DATA_W    = 40;
    localparam logic [WAIT_W-1:0] WAIT_SAT = {1'b0, 32'hFFFF_FFFF};

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_COLLECT = 3'd4,
        OP_QUERY   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        SCAN_FRONT,
        SCAN_QUERY,
        SCAN_DUE_INIT,
        SCAN_DUE
    } scan_mode_t;

    typedef enum logic [2:0] {
        RES_FAIL,
        RES_OK,
        RES_ADD,
        RES_RESET,
        RES_QUERY,
        RES_COL
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REF_WR,
        ST_RST_CHK,
        ST_SCAN_FRONT,
        ST_FRONT_RES,
        ST_SCAN_QUERY,
        ST_QUERY_RES,
        ST_SCAN_COL,
        ST_COL_POST,
        ST_COL_UPD,
        ST_EMIT,
        ST_EMIT_COL
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       rd_req;
        logic       rd_best;
        logic       wr_add;
        logic       wr_refresh;
        logic       wr_reset;
        logic       clr_act;
        logic       col_upd;
        logic       res_set;
        res_kind_t  res_kind;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       sid_valid;
        logic       sid_active;
        logic       ivl_eq;
        logic       from_now;
        logic       scan_done;
        logic       best_vld;
        logic       col_more;
        logic       out_free;
    } status_t;

endpackage

/* src/tts_datapath.sv */
// ---------------------------------------------------------------------------
// Timer table scheduler datapath
// Slot flags, interval and expiry memories, slot scanner and result register.
// ---------------------------------------------------------------------------
`include "timer_table_scheduler_unit_defines.svh"

module tts_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tts_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]                     s_tuser,
    input  tts_pkg::cmd_t                  cmd_i,
    output tts_pkg::status_t               status_o,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tts_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import tts_pkg::*;

    logic [2:0]               op_q;
    logic [TIME_BITS-1:0]     now_q;
    logic [3:0]               sid_q;
    logic [INTERVAL_BITS-1:0] ivl_q;
    logic                     per_q;
    logic                     fnow_q;

    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] periodic_reg;
    logic [SLOTS-1:0] due_reg;

    logic [INTERVAL_BITS-1:0] ivl_mem [SLOTS];
    logic [EXP_W-1:0]         exp_mem [SLOTS];
    logic [INTERVAL_BITS-1:0] rd_ivl_reg;
    logic [EXP_W-1:0]         rd_exp_reg;

    logic              scan_busy_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    scan_mode_t        scan_mode_reg;
    logic              dvalid_reg;
    logic [SLOT_W-1:0] didx_reg;

    logic              best_vld_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [EXP_W-1:0]  best_exp_reg;
    logic              front_clr_reg;
    logic [SLOT_W-1:0] tgt_idx_reg;
    logic [EXP_W-1:0]  tgt_exp_reg;

    logic              res_ok_reg;
    logic [3:0]        res_slot_reg;
    logic              res_front_reg;
    logic [WAIT_W-1:0] res_wait_reg;
    logic              res_last_reg;

    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic [SLOT_W-1:0]        sid_idx;
    logic [SLOT_W-1:0]        free_idx;
    logic                     full;
    logic [SLOT_W-1:0]        rd_addr;
    logic [SLOT_W-1:0]        wr_addr;
    logic                     ivl_we;
    logic                     exp_we;
    logic [EXP_W-1:0]         wr_exp;
    logic [EXP_W-1:0]         now_ext;
    logic [EXP_W-1:0]         add_exp;
    logic [EXP_W-1:0]         rearm_exp;
    logic [TIME_BITS-1:0]     rst_start;
    logic [EXP_W-1:0]         rst_exp;
    logic                     cand;
    logic                     due_now;
    logic                     front_hit;
    logic [SLOTS-1:0]         best_mask;
    logic [EXP_W-1:0]         diff;
    logic [WAIT_W-1:0]        query_wait;

    assign sid_idx   = SLOT_W'(sid_q);
    assign now_ext   = {1'b0, now_q};
    assign add_exp   = now_ext + EXP_W'(ivl_q);
    assign rearm_exp = now_ext + EXP_W'(rd_ivl_reg);
    assign rst_start = fnow_q ? now_q :
                       (rd_exp_reg[TIME_BITS-1:0] - TIME_BITS'(rd_ivl_reg));
    assign rst_exp   = {1'b0, rst_start} + EXP_W'(ivl_q);
    assign best_mask = SLOTS'(1) << best_idx_reg;

    always_comb begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_idx = SLOT_W'(i);
                full     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_item) begin
            op_q   <= s_tuser;
            now_q  <= s_tdata[TIME_BITS-1:0];
            sid_q  <= s_tdata[51:48];
            ivl_q  <= s_tdata[52 +: INTERVAL_BITS];
            per_q  <= s_tdata[84];
            fnow_q <= s_tdata[85];
        end
    end

    always_comb begin
        wr_addr = sid_idx;
        ivl_we  = 1'b0;
        exp_we  = 1'b0;
        wr_exp  = rearm_exp;
        if (cmd_i.wr_add) begin
            wr_addr = free_idx;
            ivl_we  = 1'b1;
            exp_we  = 1'b1;
            wr_exp  = add_exp;
        end else if (cmd_i.wr_refresh) begin
            exp_we  = 1'b1;
        end else if (cmd_i.wr_reset) begin
            ivl_we  = 1'b1;
            exp_we  = 1'b1;
            wr_exp  = rst_exp;
        end else if (cmd_i.col_upd && periodic_reg[best_idx_reg]) begin
            wr_addr = best_idx_reg;
            exp_we  = 1'b1;
        end
    end

    always_comb begin
        if (scan_busy_reg) begin
            rd_addr = scan_cnt_reg;
        end else if (cmd_i.rd_best) begin
            rd_addr = best_idx_reg;
        end else begin
            rd_addr = sid_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (ivl_we) begin
            ivl_mem[wr_addr] <= ivl_q;
        end
        if (exp_we) begin
            exp_mem[wr_addr] <= wr_exp;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_busy_reg || cmd_i.rd_req) begin
            rd_ivl_reg <= ivl_mem[rd_addr];
            rd_exp_reg <= exp_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            periodic_reg <= '0;
        end else begin
            if (cmd_i.wr_add) begin
                active_reg[free_idx]   <= 1'b1;
                periodic_reg[free_idx] <= per_q;
            end
            if (cmd_i.clr_act) begin
                active_reg[sid_idx] <= 1'b0;
            end
            if (cmd_i.col_upd && !periodic_reg[best_idx_reg]) begin
                active_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg <= 1'b0;
            dvalid_reg    <= 1'b0;
        end else begin
            dvalid_reg <= scan_busy_reg;
            if (cmd_i.scan_start) begin
                scan_busy_reg <= 1'b1;
            end else if (scan_busy_reg && scan_cnt_reg == SLOT_W'(SLOTS - 1)) begin
                scan_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        didx_reg <= scan_cnt_reg;
        if (cmd_i.scan_start) begin
            scan_cnt_reg  <= '0;
            scan_mode_reg <= cmd_i.scan_mode;
        end else if (scan_busy_reg) begin
            scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
        end
    end

    always_comb begin
        due_now   = active_reg[didx_reg] && (rd_exp_reg <= now_ext);
        front_hit = (didx_reg != tgt_idx_reg) && active_reg[didx_reg] &&
                    ((rd_exp_reg < tgt_exp_reg) ||
                     ((rd_exp_reg == tgt_exp_reg) && (didx_reg < tgt_idx_reg)));
        case (scan_mode_reg)
            SCAN_QUERY:    cand = active_reg[didx_reg];
            SCAN_DUE_INIT: cand = due_now;
            SCAN_DUE:      cand = due_reg[didx_reg];
            default:       cand = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            due_reg <= '0;
        end else if (dvalid_reg && scan_mode_reg == SCAN_DUE_INIT) begin
            due_reg[didx_reg] <= due_now;
        end else if (cmd_i.col_upd) begin
            due_reg[best_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.scan_start) begin
            best_vld_reg  <= 1'b0;
            front_clr_reg <= 1'b0;
        end else if (dvalid_reg) begin
            if (cand && (!best_vld_reg || rd_exp_reg < best_exp_reg)) begin
                best_vld_reg <= 1'b1;
                best_idx_reg <= didx_reg;
                best_exp_reg <= rd_exp_reg;
            end
            if (scan_mode_reg == SCAN_FRONT && front_hit) begin
                front_clr_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.wr_add) begin
            tgt_idx_reg <= free_idx;
            tgt_exp_reg <= add_exp;
        end else if (cmd_i.wr_reset) begin
            tgt_idx_reg <= sid_idx;
            tgt_exp_reg <= rst_exp;
        end
    end

    always_comb begin
        diff = best_exp_reg - now_ext;
        if (!best_vld_reg) begin
            query_wait = '1;
        end else if (now_ext > best_exp_reg) begin
            query_wait = '0;
        end else if (diff > EXP_W'(WAIT_SAT)) begin
            query_wait = WAIT_SAT;
        end else begin
            query_wait = WAIT_W'(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.res_set) begin
            res_ok_reg    <= 1'b1;
            res_slot_reg  <= '0;
            res_front_reg <= 1'b0;
            res_wait_reg  <= '0;
            res_last_reg  <= 1'b1;
            case (cmd_i.res_kind)
                RES_FAIL: res_ok_reg <= 1'b0;
                RES_ADD: begin
                    res_slot_reg  <= 4'(tgt_idx_reg);
                    res_front_reg <= !front_clr_reg;
                end
                RES_RESET: res_front_reg <= !front_clr_reg;
                RES_QUERY: res_wait_reg <= query_wait;
                RES_COL: begin
                    res_slot_reg <= 4'(best_idx_reg);
                    res_last_reg <= !status_o.col_more;
                end
                default: res_ok_reg <= 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_tdata_reg <= {1'b0, res_wait_reg, res_front_reg, res_slot_reg, res_ok_reg};
            m_tlast_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign status_o.op         = op_q;
    assign status_o.full       = full;
    assign status_o.sid_valid  = ({1'b0, sid_q} < 5'(SLOTS));
    assign status_o.sid_active = status_o.sid_valid && active_reg[sid_idx];
    assign status_o.ivl_eq     = (rd_ivl_reg == ivl_q);
    assign status_o.from_now   = fnow_q;
    assign status_o.scan_done  = dvalid_reg && (didx_reg == SLOT_W'(SLOTS - 1));
    assign status_o.best_vld   = best_vld_reg;
    assign status_o.col_more   = |(due_reg & ~best_mask);
    assign status_o.out_free   = !m_tvalid_reg || m_tready;

    `TTS_ASSERT_NOW(a_add_free, cmd_i.wr_add, !full, "add issued with no free slot")
    `TTS_ASSERT_NOW(a_col_due, cmd_i.col_upd, best_vld_reg && due_reg[best_idx_reg], "slot not due")
    `TTS_ASSERT_NOW(a_scan_idle, cmd_i.scan_start, !scan_busy_reg && !dvalid_reg, "scan restarted")
    `TTS_ASSERT_NEXT(a_out_load, cmd_i.out_load, m_tvalid_reg, "loaded word not presented")

endmodule

/* src/tts_ctrl.sv */
// ---------------------------------------------------------------------------
// Timer table scheduler controller
// Sequences each operation through reads, scans, writes and result words.
// ---------------------------------------------------------------------------
module tts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tts_pkg::status_t status_i,
    output tts_pkg::cmd_t    cmd_o
);
    import tts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_o          = '0;
        cmd_o.scan_mode = SCAN_FRONT;
        cmd_o.res_kind  = RES_FAIL;
        s_tready       = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.load_item = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (op_t'(status_i.op))
                    OP_ADD: begin
                        if (status_i.full) begin
                            cmd_o.res_set = 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            cmd_o.wr_add     = 1'b1;
                            cmd_o.scan_start = 1'b1;
                            state_next = ST_SCAN_FRONT;
                        end
                    end
                    OP_CANCEL: begin
                        cmd_o.res_set  = 1'b1;
                        cmd_o.res_kind = status_i.sid_active ? RES_OK : RES_FAIL;
                        cmd_o.clr_act  = status_i.sid_active;
                        state_next = ST_EMIT;
                    end
                    OP_REFRESH: begin
                        if (status_i.sid_active) begin
                            cmd_o.rd_req = 1'b1;
                            state_next = ST_REF_WR;
                        end else begin
                            cmd_o.res_set = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    OP_RESET: begin
                        if (status_i.sid_valid) begin
                            cmd_o.rd_req = 1'b1;
                            state_next = ST_RST_CHK;
                        end else begin
                            cmd_o.res_set = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    OP_COLLECT: begin
                        cmd_o.scan_start = 1'b1;
                        cmd_o.scan_mode  = SCAN_DUE_INIT;
                        state_next = ST_SCAN_COL;
                    end
                    OP_QUERY: begin
                        cmd_o.scan_start = 1'b1;
                        cmd_o.scan_mode  = SCAN_QUERY;
                        state_next = ST_SCAN_QUERY;
                    end
                    default: begin
                        cmd_o.res_set = 1'b1;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_REF_WR: begin
                cmd_o.wr_refresh = 1'b1;
                cmd_o.res_set    = 1'b1;
                cmd_o.res_kind   = RES_OK;
                state_next = ST_EMIT;
            end
            ST_RST_CHK: begin
                if (status_i.ivl_eq && !status_i.from_now) begin
                    cmd_o.res_set  = 1'b1;
                    cmd_o.res_kind = RES_OK;
                    state_next = ST_EMIT;
                end else if (!status_i.sid_active) begin
                    cmd_o.res_set = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd_o.wr_reset   = 1'b1;
                    cmd_o.scan_start = 1'b1;
                    state_next = ST_SCAN_FRONT;
                end
            end
            ST_SCAN_FRONT: begin
                if (status_i.scan_done) begin
                    state_next = ST_FRONT_RES;
                end
            end
            ST_FRONT_RES: begin
                cmd_o.res_set  = 1'b1;
                cmd_o.res_kind = (status_i.op == OP_ADD) ? RES_ADD : RES_RESET;
                state_next = ST_EMIT;
            end
            ST_SCAN_QUERY: begin
                if (status_i.scan_done) begin
                    state_next = ST_QUERY_RES;
                end
            end
            ST_QUERY_RES: begin
                cmd_o.res_set  = 1'b1;
                cmd_o.res_kind = RES_QUERY;
                state_next = ST_EMIT;
            end
            ST_SCAN_COL: begin
                if (status_i.scan_done) begin
                    state_next = ST_COL_POST;
                end
            end
            ST_COL_POST: begin
                if (status_i.best_vld) begin
                    cmd_o.rd_req  = 1'b1;
                    cmd_o.rd_best = 1'b1;
                    state_next = ST_COL_UPD;
                end else begin
                    cmd_o.res_set = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_COL_UPD: begin
                cmd_o.col_upd  = 1'b1;
                cmd_o.res_set  = 1'b1;
                cmd_o.res_kind = RES_COL;
                state_next = ST_EMIT_COL;
            end
            ST_EMIT: begin
                if (status_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_COL: begin
                if (status_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    if (status_i.col_more) begin
                        cmd_o.scan_start = 1'b1;
                        cmd_o.scan_mode  = SCAN_DUE;
                        state_next = ST_SCAN_COL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* src/timer_table_scheduler_unit.sv */
// ---------------------------------------------------------------------------
// Timer table scheduler
// Sixteen one-shot or periodic timers with add, cancel, refresh, reset,
// collect and query operations on a stream interface.
// ---------------------------------------------------------------------------
// One word is taken at a time. Add, reset, query and collect use the slot
// scan, and collect scans again after each due timer it reports while
// more remain due. The scan reads the expiry memory through its single
// read port at one slot per cycle. A finished result word waits in the
// output register while the next input word is accepted.
module timer_table_scheduler_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_time[47:0], slot_id[51:48], interval_ms[83:52], periodic[84], from_now[85]
    input  logic [tts_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok[0], timer_slot[4:1], at_front[5], wait_time[38:6]
    output logic [tts_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import tts_pkg::*;

    cmd_t    cmd;
    status_t status;

    tts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    tts_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_i    (cmd),
        .status_o (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
